>>> rtl/review_record_decoder_crc32_assert.svh
// Assertion macros for the review record decoder checker.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef REVIEW_RECORD_DECODER_CRC32_ASSERT_SVH
`define REVIEW_RECORD_DECODER_CRC32_ASSERT_SVH

// Same-cycle implication.
`define RRD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("review record decoder assertion failed");

// Next-cycle implication.
`define RRD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("review record decoder assertion failed");

`endif

>>> rtl/rrd_pkg.sv
// Shared types, constants and the bytewise CRC-32 step for the review record decoder.
// No dependencies.
package rrd_pkg;

  localparam int unsigned RecordBytes = 64;
  localparam int unsigned CheckOffset = 60;
  localparam int unsigned CountW      = $clog2(RecordBytes + 1);
  localparam int unsigned IdxW        = $clog2(RecordBytes);

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcOnes = 32'hFFFFFFFF;

  localparam logic [7:0] MaxStateReset = 8'd3;
  localparam logic [2:0] RatingMin     = 3'd1;
  localparam logic [2:0] RatingMax     = 3'd4;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_LENGTH  = 3'd1,
    ST_BAD_CHECK   = 3'd2,
    ST_BAD_RATING  = 3'd3,
    ST_BAD_STATE   = 3'd4,
    ST_BAD_FLAGS   = 3'd5,
    ST_NON_FINITE  = 3'd6
  } status_e;

  typedef logic [RecordBytes-1:0][7:0] record_t;

  typedef struct packed {
    logic        valid;
    logic        len_ok;
    logic [31:0] crc;
  } rec_done_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [63:0]        id_low;
    logic [63:0]        id_high;
    logic signed [63:0] card_number;
    logic signed [63:0] reviewed_at;
    logic [2:0]         rating;
    logic [7:0]         previous_state;
    logic [7:0]         next_state;
    logic [63:0]        stability_pair;
    logic [63:0]        difficulty_pair;
    logic signed [31:0] interval;
    logic [31:0]        elapsed_and_duration;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic exp_all_ones(input logic [31:0] w);
    return &w[30:23];
  endfunction

endpackage

>>> rtl/rrd_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload type is set per instance; no other dependencies.
interface rrd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/rrd_collect.sv
// Byte collector: record store, byte count, overrun flag and running CRC-32.
// Depends on rrd_pkg.
module rrd_collect (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              drain_i,
  output rrd_pkg::record_t  record_o,
  output rrd_pkg::rec_done_t done_o
);
  import rrd_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic              too_long_q, too_long_d;
  logic [31:0]       crc_q, crc_d;
  rec_done_t         done_q, done_d;
  record_t           rec_q;
  logic              store_en;

  assign store_en = beat_i && (count_q < CountW'(RecordBytes));

  always_comb begin
    count_d    = count_q;
    too_long_d = too_long_q;
    crc_d      = crc_q;
    done_d     = done_q;
    if (drain_i) begin
      done_d.valid = 1'b0;
    end
    if (beat_i) begin
      if (store_en) begin
        if (count_q < CountW'(CheckOffset)) begin
          crc_d = crc_byte(crc_q, data_byte_i);
        end
        count_d = count_q + CountW'(1);
      end else begin
        too_long_d = 1'b1;
      end
      if (last_byte_i) begin
        done_d.valid  = 1'b1;
        done_d.len_ok = !too_long_q && (count_q == CountW'(RecordBytes - 1));
        done_d.crc    = crc_q ^ CrcOnes;
        count_d       = '0;
        too_long_d    = 1'b0;
        crc_d         = CrcOnes;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      too_long_q <= 1'b0;
      crc_q      <= CrcOnes;
      done_q     <= '0;
    end else begin
      count_q    <= count_d;
      too_long_q <= too_long_d;
      crc_q      <= crc_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      rec_q[count_q[IdxW-1:0]] <= data_byte_i;
    end
  end

  assign record_o = rec_q;
  assign done_o   = done_q;

endmodule

>>> rtl/review_record_decoder_crc32.sv
// Top level of the review record decoder with CRC-32 check.
// Depends on rrd_pkg, rrd_stream_if and rrd_collect.
//
// Usage:
//   in_i carries one record byte per beat (data_byte, last_byte marks the final
//   byte). out_o carries one result per record: status and the decoded fields,
//   all fields zero unless status is ok. cfg_we_i/cfg_wdata_i write
//   max_state_code (reset value 3); write it only while the block is idle.
//   Throughput: one byte per cycle, back to back across records, with out_o ready.
//   The edge that takes the final byte latches the finished record and CRC in
//   the collector; the checked result is then latched into the output register
//   once that register is free.
//   A stalled receiver holds the result in the output register; one further
//   finished record waits in the check stage, and in_i.ready drops only when
//   both are full, so the record store is never overwritten before it is read.
//   Reset clears the byte count, overrun flag, CRC and all valid flags; the
//   record store itself is not cleared.
module review_record_decoder_crc32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrd_stream_if.sink   in_i,
  rrd_stream_if.source out_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import rrd_pkg::*;

  logic       beat;
  logic       out_free;
  logic       out_valid_q, out_valid_d;
  result_t    out_q, res;
  logic [7:0] max_state_q;
  record_t    rec;
  rec_done_t  done;
  status_e    status;
  logic [2:0] rating_in;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = !done.valid || out_free;
  assign beat       = in_i.valid && in_i.ready;

  rrd_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .data_byte_i (in_i.payload.data_byte),
    .last_byte_i (in_i.payload.last_byte),
    .drain_i     (out_free),
    .record_o    (rec),
    .done_o      (done)
  );

  assign rating_in = rec[32][2:0];

  always_comb begin
    if (!done.len_ok) begin
      status = ST_BAD_LENGTH;
    end else if (rec[63:60] != done.crc) begin
      status = ST_BAD_CHECK;
    end else if (rec[32] < {5'd0, RatingMin} || rec[32] > {5'd0, RatingMax}) begin
      status = ST_BAD_RATING;
    end else if (rec[33] > max_state_q || rec[34] > max_state_q) begin
      status = ST_BAD_STATE;
    end else if (rec[35] != 8'd0) begin
      status = ST_BAD_FLAGS;
    end else if (exp_all_ones(rec[39:36]) || exp_all_ones(rec[43:40]) ||
                 exp_all_ones(rec[47:44]) || exp_all_ones(rec[51:48])) begin
      status = ST_NON_FINITE;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.id_low               = rec[7:0];
      res.id_high              = rec[15:8];
      res.card_number          = rec[23:16];
      res.reviewed_at          = rec[31:24];
      res.rating               = rating_in;
      res.previous_state       = rec[33];
      res.next_state           = rec[34];
      res.stability_pair       = rec[43:36];
      res.difficulty_pair      = rec[51:44];
      res.interval             = rec[55:52];
      res.elapsed_and_duration = rec[59:56];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (done.valid && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      max_state_q <= MaxStateReset;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_state_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done.valid && out_free) begin
      out_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

>>> rtl/rrd_checker.sv
// Port-level checker for the review record decoder, bound to the top level.
// Depends on rrd_pkg and review_record_decoder_crc32_assert.svh.
module rrd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input rrd_pkg::result_t   out_payload_i
);
  import rrd_pkg::*;

`include "review_record_decoder_crc32_assert.svh"

  logic is_ok;
  logic fields_zero;

  assign is_ok       = (out_payload_i.status == ST_OK);
  assign fields_zero = (out_payload_i.id_low == 64'd0) && (out_payload_i.id_high == 64'd0) &&
                       (out_payload_i.card_number == 64'sd0) &&
                       (out_payload_i.reviewed_at == 64'sd0) &&
                       (out_payload_i.rating == 3'd0) &&
                       (out_payload_i.previous_state == 8'd0) &&
                       (out_payload_i.next_state == 8'd0) &&
                       (out_payload_i.stability_pair == 64'd0) &&
                       (out_payload_i.difficulty_pair == 64'd0) &&
                       (out_payload_i.interval == 32'sd0) &&
                       (out_payload_i.elapsed_and_duration == 32'd0);

  `RRD_ASSERT_IMP(a_bad_fields_zero, out_valid_i && !is_ok, fields_zero)
  `RRD_ASSERT_IMP(a_ok_rating_range, out_valid_i && is_ok,
                  out_payload_i.rating >= RatingMin && out_payload_i.rating <= RatingMax)
  `RRD_ASSERT_IMP(a_status_code, out_valid_i, out_payload_i.status <= ST_NON_FINITE)
  `RRD_ASSERT_NXT(a_stall_hold, out_valid_i && !out_ready_i,
                  out_valid_i && $stable(out_payload_i))

endmodule

bind review_record_decoder_crc32 rrd_checker u_rrd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);

>>> tb/review_check_pkg.sv
// Scoreboard for the review record decoder testbench: byte-level predictor and result checker.
// Depends on rrd_pkg for the beat and result types and the record constants.
package review_check_pkg;
  import rrd_pkg::*;

  class review_scoreboard;
    logic [7:0]  record_bytes [RecordBytes];
    logic [31:0] crc_acc;
    int unsigned byte_cnt;
    bit          overrun;
    logic [7:0]  max_state;
    result_t     expected_q [$];
    int unsigned n_results;
    int unsigned n_errors;

    function new();
      restart();
      max_state = MaxStateReset;
      n_results = 0;
      n_errors  = 0;
    endfunction

    static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        if (c[0] ^ b[i]) begin
          c = (c >> 1) ^ CrcPoly;
        end else begin
          c = c >> 1;
        end
      end
      return c;
    endfunction

    function void restart();
      crc_acc  = CrcOnes;
      byte_cnt = 0;
      overrun  = 1'b0;
    endfunction

    function logic [63:0] le_bytes(int unsigned off, int unsigned n);
      logic [63:0] v;
      v = '0;
      for (int unsigned i = 0; i < n; i++) begin
        v[8*i +: 8] = record_bytes[off+i];
      end
      return v;
    endfunction

    function void note_beat(in_beat_t beat);
      result_t     want;
      status_e     st;
      logic [63:0] w;
      if (byte_cnt < RecordBytes) begin
        record_bytes[byte_cnt] = beat.data_byte;
        if (byte_cnt < CheckOffset) begin
          crc_acc = crc_step(crc_acc, beat.data_byte);
        end
        byte_cnt++;
      end else begin
        overrun = 1'b1;
      end
      if (!beat.last_byte) return;

      st = ST_OK;
      w  = le_bytes(CheckOffset, 4);
      if (overrun || byte_cnt != RecordBytes) begin
        st = ST_BAD_LENGTH;
      end else if (w[31:0] != ~crc_acc) begin
        st = ST_BAD_CHECK;
      end else if (record_bytes[32] < RatingMin || record_bytes[32] > RatingMax) begin
        st = ST_BAD_RATING;
      end else if (record_bytes[33] > max_state || record_bytes[34] > max_state) begin
        st = ST_BAD_STATE;
      end else if (record_bytes[35] != 8'd0) begin
        st = ST_BAD_FLAGS;
      end else begin
        for (int k = 0; k < 4; k++) begin
          w = le_bytes(36 + 4*k, 4);
          if (w[30:23] == 8'hFF) st = ST_NON_FINITE;
        end
      end

      want = '0;
      want.status = st;
      if (st == ST_OK) begin
        want.id_low          = le_bytes(0, 8);
        want.id_high         = le_bytes(8, 8);
        want.card_number     = le_bytes(16, 8);
        want.reviewed_at     = le_bytes(24, 8);
        want.rating          = record_bytes[32][2:0];
        want.previous_state  = record_bytes[33];
        want.next_state      = record_bytes[34];
        want.stability_pair  = le_bytes(36, 8);
        want.difficulty_pair = le_bytes(44, 8);
        w = le_bytes(52, 4);
        want.interval = w[31:0];
        w = le_bytes(56, 4);
        want.elapsed_and_duration = w[31:0];
      end
      expected_q.push_back(want);
      restart();
    endfunction

    function void flag(string msg);
      n_errors++;
      if (n_errors <= 10) $display("MISMATCH %s", msg);
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        flag($sformatf("result %0d %s: expected %h, got %h", n_results, name, want, got));
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("result %0d arrived with nothing pending", n_results));
        n_results++;
        return;
      end
      want = expected_q.pop_front();
      cmp_field("status", want.status, got.status);
      cmp_field("id_low", want.id_low, got.id_low);
      cmp_field("id_high", want.id_high, got.id_high);
      cmp_field("card_number", want.card_number, got.card_number);
      cmp_field("reviewed_at", want.reviewed_at, got.reviewed_at);
      cmp_field("rating", want.rating, got.rating);
      cmp_field("previous_state", want.previous_state, got.previous_state);
      cmp_field("next_state", want.next_state, got.next_state);
      cmp_field("stability_pair", want.stability_pair, got.stability_pair);
      cmp_field("difficulty_pair", want.difficulty_pair, got.difficulty_pair);
      cmp_field("interval", want.interval, got.interval);
      cmp_field("elapsed_and_duration", want.elapsed_and_duration, got.elapsed_and_duration);
      n_results++;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

>>> tb/tb.sv
// Top-level testbench for review_record_decoder_crc32: directed and random records,
// random stalls on both streams, max_state_code sweeps. Depends on rrd_pkg,
// rrd_stream_if and review_check_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrd_pkg::*;
  import review_check_pkg::*;

  localparam int unsigned LongHold      = 400;
  localparam int unsigned IdleLimit     = 5000;
  localparam int unsigned RandomBytes   = 570;
  localparam int unsigned RandomRecords = 9;

  typedef logic [7:0] record_buf_t [RecordBytes];

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  rrd_stream_if #(.payload_t(in_beat_t)) beat_if ();
  rrd_stream_if #(.payload_t(result_t))  res_if ();

  review_record_decoder_crc32 uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (beat_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  review_scoreboard sb;
  int unsigned      tx_gap_pct;
  int unsigned      rx_stall_pct;
  int unsigned      idle_cycles;
  int unsigned      rand_bytes;
  int unsigned      rand_records;
  bit               long_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  function automatic record_buf_t seal(record_buf_t r);
    logic [31:0] crc;
    crc = CrcOnes;
    for (int i = 0; i < CheckOffset; i++) begin
      crc = review_scoreboard::crc_step(crc, r[i]);
    end
    crc = ~crc;
    for (int i = 0; i < 4; i++) begin
      r[CheckOffset+i] = crc[8*i +: 8];
    end
    return r;
  endfunction

  function automatic record_buf_t make_record(logic [7:0] max_st);
    record_buf_t r;
    int unsigned m;
    m = max_st;
    for (int i = 0; i < RecordBytes; i++) begin
      r[i] = 8'($urandom);
    end
    r[32] = 8'($urandom_range(1, 4));
    r[33] = 8'($urandom_range(0, m));
    r[34] = 8'($urandom_range(0, m));
    r[35] = 8'd0;
    for (int k = 0; k < 4; k++) begin
      if (r[39+4*k][6:0] == 7'h7F && r[38+4*k][7]) r[38+4*k][7] = 1'b0;
    end
    return seal(r);
  endfunction

  task automatic idle(int unsigned n);
    beat_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_beat(logic [7:0] d, logic last);
    if ($urandom_range(0, 99) < tx_gap_pct) idle(gap_len());
    beat_if.valid   <= 1'b1;
    beat_if.payload <= {d, last};
    do @(posedge clk_i); while (beat_if.ready !== 1'b1);
  endtask

  task automatic send_record(record_buf_t r, int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_beat((i < RecordBytes) ? r[i] : 8'($urandom), i == len - 1);
    end
  endtask

  task automatic drain();
    beat_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_max_state(logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.max_state = v;
  endtask

  task automatic directed_records();
    record_buf_t base;
    record_buf_t r;
    logic [7:0]  ratings [4];
    ratings = '{8'd0, 8'd5, 8'd9, 8'hFF};
    for (int i = 0; i < RecordBytes; i++) base[i] = 8'd0;
    base[32] = 8'd1;
    base = seal(base);
    send_record(base, RecordBytes);

    for (int i = 0; i < RecordBytes; i++) r[i] = 8'hFF;
    r[32] = 8'd4;
    r[33] = MaxStateReset;
    r[34] = MaxStateReset;
    r[35] = 8'd0;
    for (int k = 0; k < 4; k++) r[38+4*k] = 8'h7F;
    send_record(seal(r), RecordBytes);

    send_record(base, 1);
    send_record(base, RecordBytes - 1);
    send_record(base, RecordBytes + 1);

    r = base;
    r[CheckOffset] ^= 8'h01;
    send_record(r, RecordBytes);
    r = base;
    r[CheckOffset-1] ^= 8'h80;
    send_record(r, RecordBytes);

    for (int i = 0; i < 4; i++) begin
      r = base;
      r[32] = ratings[i];
      send_record(seal(r), RecordBytes);
    end

    r = base;
    r[33] = MaxStateReset + 8'd1;
    send_record(seal(r), RecordBytes);
    r = base;
    r[34] = MaxStateReset + 8'd1;
    send_record(seal(r), RecordBytes);

    r = base;
    r[35] = 8'h01;
    send_record(seal(r), RecordBytes);
    r = base;
    r[35] = 8'h80;
    send_record(seal(r), RecordBytes);

    for (int k = 0; k < 4; k++) begin
      r = base;
      r[39+4*k] = k[0] ? 8'hFF : 8'h7F;
      r[38+4*k] = 8'h80 | 8'(k);
      send_record(seal(r), RecordBytes);
    end

    // several faults at once: rating wins over state, flags and exponent
    r = base;
    r[32] = 8'd0;
    r[33] = 8'hFF;
    r[35] = 8'h01;
    r[38] = 8'h80;
    r[39] = 8'h7F;
    send_record(seal(r), RecordBytes);
    send_record(r, RecordBytes - 1);
  endtask

  task automatic random_record(logic [7:0] max_st);
    record_buf_t r;
    int unsigned kind;
    int unsigned len;
    int unsigned k;
    int unsigned m;
    m    = max_st;
    r    = make_record(max_st);
    len  = RecordBytes;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
    end else if (kind < 62) begin
      r[32] = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(5, 255));
      r = seal(r);
    end else if (kind < 69 && m < 255) begin
      r[33 + $urandom_range(0, 1)] = 8'($urandom_range(m + 1, 255));
      r = seal(r);
    end else if (kind < 75) begin
      r[35] = 8'($urandom_range(1, 255));
      r = seal(r);
    end else if (kind < 82) begin
      k = $urandom_range(0, 3);
      r[39+4*k][6:0] = 7'h7F;
      r[38+4*k][7]   = 1'b1;
      r = seal(r);
    end else if (kind < 86) begin
      for (int i = 0; i < RecordBytes; i++) r[i] = 8'($urandom);
    end else if (kind < 92) begin
      k = $urandom_range(0, RecordBytes - 1);
      r[k] ^= 8'(1 << $urandom_range(0, 7));
    end else begin
      len = $urandom_range(0, 1) ? $urandom_range(1, RecordBytes - 1)
                                 : $urandom_range(RecordBytes + 1, 100);
    end
    send_record(r, len);
    rand_bytes += len;
    rand_records++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (beat_if.valid && beat_if.ready) sb.note_beat(beat_if.payload);
      if (res_if.valid && res_if.ready) sb.check_result(res_if.payload);
      if ((beat_if.valid && beat_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        res_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        res_if.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    sb              = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 8'd0;
    beat_if.valid   = 1'b0;
    beat_if.payload = '0;
    tx_gap_pct      = 0;
    rx_stall_pct    = 0;
    idle_cycles     = 0;
    rand_bytes      = 0;
    rand_records    = 0;
    long_hold_req   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_gap_pct   = 10;
    rx_stall_pct = 10;
    directed_records();
    drain();

    set_max_state(8'd0);
    repeat (3) begin
      tx_gap_pct   = pick_pct();
      rx_stall_pct = pick_pct();
      random_record(8'd0);
    end
    drain();

    // hold the sink while beats keep coming, so the input stalls
    set_max_state(8'hFF);
    tx_gap_pct    = 0;
    rx_stall_pct  = 0;
    long_hold_req = 1'b1;
    repeat (3) random_record(8'hFF);
    drain();

    set_max_state(8'($urandom_range(1, 254)));
    repeat (3) begin
      tx_gap_pct   = pick_pct();
      rx_stall_pct = pick_pct();
      random_record(sb.max_state);
    end
    drain();

    set_max_state(MaxStateReset);
    while (rand_bytes < RandomBytes || rand_records < RandomRecords) begin
      tx_gap_pct   = pick_pct();
      rx_stall_pct = pick_pct();
      random_record(MaxStateReset);
    end
    drain();
    repeat (6) @(posedge clk_i);

    if (sb.n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/rrd_pkg.sv
rtl/rrd_stream_if.sv
rtl/rrd_collect.sv
rtl/review_record_decoder_crc32.sv
rtl/rrd_checker.sv
tb/review_check_pkg.sv
tb/tb.sv
